[src/rtrl_pkg.sv]
// ----------------------------------------------------------------------------
// rtrl_pkg - shared types and constants for the run table reference lookup
// Table geometry, field widths, command and register codes, sequencer states
// and the table port bundles.
// ----------------------------------------------------------------------------
package rtrl_pkg;

	localparam int MAX_RUNS = 1024;
	localparam int ADDR_W   = $clog2(MAX_RUNS);
	localparam int CNT_W    = ADDR_W + 1;
	localparam int ROW_W    = 16;
	localparam int REF_W    = 16;
	localparam int NEXT_W   = ROW_W + 1;
	localparam int NULL_W   = 16;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 3;

	localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_RUNS);
	localparam logic [NEXT_W-1:0] NO_NEXT  = {1'b1, {ROW_W{1'b0}}};
	localparam logic [NULL_W-1:0] NULL_MAX = {NULL_W{1'b1}};

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	// register select is the word address bit
	localparam logic REG_RUN_COUNT = 1'b0;
	localparam logic REG_DICT_SIZE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SEARCH,
		ST_SCMP,
		ST_FIN
	} seq_state_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [ROW_W-1:0]  start_row;
		logic [REF_W-1:0]  ref_val;
	} tbl_wr_t;

	typedef struct packed {
		logic [ADDR_W-1:0] start_addr;
		logic [ADDR_W-1:0] ref_addr;
	} tbl_rd_t;

	// zero acts as one, anything past the table acts as the table size
	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cnt);
		logic [CNT_W-1:0] res;
		if (cnt == '0) begin
			res = CNT_W'(1);
		end else if (cnt > MAX_CNT) begin
			res = MAX_CNT;
		end else begin
			res = cnt;
		end
		return res;
	endfunction

endpackage

[src/rtrl_table.sv]
// ----------------------------------------------------------------------------
// rtrl_table - run table storage
// Start rows and references of the runs, one write port shared by both
// arrays and one registered read port on each.
// ----------------------------------------------------------------------------
module rtrl_table
	import rtrl_pkg::*;
(
	input  logic             clk,
	input  tbl_wr_t          wr,
	input  tbl_rd_t          rd,
	output logic [ROW_W-1:0] start_rd,
	output logic [REF_W-1:0] ref_rd
);

	logic [ROW_W-1:0] start_mem [MAX_RUNS];
	logic [REF_W-1:0] ref_mem   [MAX_RUNS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			start_mem[wr.addr] <= wr.start_row;
			ref_mem[wr.addr]   <= wr.ref_val;
		end
	end

	always_ff @(posedge clk) begin
		start_rd <= start_mem[rd.start_addr];
		ref_rd   <= ref_mem[rd.ref_addr];
	end

endmodule

[src/rtrl_cmp.sv]
// ----------------------------------------------------------------------------
// rtrl_cmp - row comparator
// Compares the row being looked up against a start row or the cursor's
// next start; shared by the cursor check and every search step.
// ----------------------------------------------------------------------------
module rtrl_cmp
	import rtrl_pkg::*;
(
	input  logic [ROW_W-1:0]  row,
	input  logic [NEXT_W-1:0] operand,
	output logic              lt,
	output logic              eq
);

	logic [NEXT_W-1:0] row_ext;

	assign row_ext = {1'b0, row};
	assign lt      = row_ext < operand;
	assign eq      = row_ext == operand;

endmodule

[src/run_table_row_ref_lookup.sv]
// ----------------------------------------------------------------------------
// run_table_row_ref_lookup - run-length table row to reference lookup
// Loads run entries and maps row ids to the reference of their run.
// ----------------------------------------------------------------------------
// A load item gives no result. A lookup ends at the cursor check if the row
// stays in the cursor's run, after one more read if it starts the next run,
// else after S binary search steps and a final read (S <= ceil(log2(n + 1))
// for n runs in use, 11 for a full table). Each search step is one
// registered table read followed by one pass through the single row
// comparator. The result is shown with valid for one cycle, the first cycle
// after busy falls, and cannot be held off: take it then. Both tables are
// uninitialized after reset; load every entry below run_count first.
module run_table_row_ref_lookup
	import rtrl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              cmd,
	input  logic [ADDR_W-1:0] run_index,
	input  logic [ROW_W-1:0]  run_start_row,
	input  logic [REF_W-1:0]  run_ref,
	input  logic [ROW_W-1:0]  row_id,
	input  logic              last_in_batch,
	output logic              valid,
	output logic [REF_W-1:0]  ref_res,
	output logic              is_null,
	output logic [NULL_W-1:0] null_total,
	output logic              batch_done,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	seq_state_t        state_q, state_d;
	logic [CNT_W-1:0]  run_count_q;
	logic [REF_W-1:0]  dict_size_q;
	logic [ROW_W-1:0]  row_q;
	logic              last_q;
	logic [CNT_W-1:0]  cur_pos_q;
	logic [NEXT_W-1:0] cur_next_q;
	logic [REF_W-1:0]  cur_ref_q;
	logic [NULL_W-1:0] nulls_q;
	logic [CNT_W-1:0]  lo_q, lo_d;
	logic [CNT_W-1:0]  hi_q, hi_d;
	logic              valid_q;
	logic [REF_W-1:0]  ref_res_q;
	logic              is_null_q;
	logic [NULL_W-1:0] null_total_q;
	logic              batch_done_q;

	tbl_wr_t           tbl_wr;
	tbl_rd_t           tbl_rd;
	logic [ROW_W-1:0]  start_rd;
	logic [REF_W-1:0]  ref_rd;

	logic [CNT_W-1:0]  cnt;
	logic [CNT_W-1:0]  mid;
	logic [CNT_W-1:0]  adv_pos;
	logic [NEXT_W-1:0] cmp_op;
	logic              cmp_lt;
	logic              cmp_eq;
	logic              accept;
	logic              apb_wr;

	logic              fin;
	logic [CNT_W-1:0]  fin_pos;
	logic [NEXT_W-1:0] fin_next;
	logic [REF_W-1:0]  fin_ref;
	logic              fin_null;
	logic [NULL_W-1:0] fin_nulls;

	assign busy    = state_q != ST_IDLE;
	assign accept  = start && !busy;
	assign pready  = 1'b1;
	assign apb_wr  = psel && penable && pwrite;
	assign cnt     = eff_count(run_count_q);
	assign mid     = lo_q + ((hi_q - lo_q) >> 1);
	assign adv_pos = cur_pos_q + CNT_W'(1);

	always_comb begin
		if (paddr[2] == REG_DICT_SIZE) begin
			prdata = APB_DW'(dict_size_q);
		end else begin
			prdata = APB_DW'(run_count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_count_q <= CNT_W'(1);
			dict_size_q <= '0;
		end else if (apb_wr) begin
			if (paddr[2] == REG_DICT_SIZE) begin
				dict_size_q <= pwdata[REF_W-1:0];
			end else begin
				run_count_q <= pwdata[CNT_W-1:0];
			end
		end
	end

	assign tbl_wr.en        = accept && (cmd == CMD_LOAD);
	assign tbl_wr.addr      = run_index;
	assign tbl_wr.start_row = run_start_row;
	assign tbl_wr.ref_val   = run_ref;

	rtrl_table u_table (
		.clk      (clk),
		.wr       (tbl_wr),
		.rd       (tbl_rd),
		.start_rd (start_rd),
		.ref_rd   (ref_rd)
	);

	always_comb begin
		if (state_q == ST_CHECK && cur_pos_q != '0) begin
			cmp_op = cur_next_q;
		end else begin
			cmp_op = {1'b0, start_rd};
		end
	end

	rtrl_cmp u_cmp (
		.row     (row_q),
		.operand (cmp_op),
		.lt      (cmp_lt),
		.eq      (cmp_eq)
	);

	always_comb begin
		state_d           = state_q;
		lo_d              = lo_q;
		hi_d              = hi_q;
		tbl_rd.start_addr = cur_pos_q[ADDR_W-1:0];
		tbl_rd.ref_addr   = cur_pos_q[ADDR_W-1:0];
		fin               = 1'b0;
		fin_pos           = cur_pos_q;
		fin_next          = cur_next_q;
		fin_ref           = cur_ref_q;
		case (state_q)
			ST_IDLE: begin
				// read the cursor's entry; it is entry 0 for a fresh cursor
				if (accept && cmd == CMD_LOOKUP) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (cur_pos_q == '0) begin
					fin_next = {1'b0, start_rd};
					fin_ref  = ref_rd;
				end
				if (cur_pos_q >= cnt || cmp_lt) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
				end else if (cmp_eq) begin
					// advance one run: ref of the run entered, start of the one after
					lo_d              = adv_pos;
					tbl_rd.start_addr = adv_pos[ADDR_W-1:0];
					tbl_rd.ref_addr   = cur_pos_q[ADDR_W-1:0];
					state_d           = ST_FIN;
				end else begin
					lo_d    = '0;
					hi_d    = cnt;
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (lo_q < hi_q) begin
					tbl_rd.start_addr = mid[ADDR_W-1:0];
					state_d           = ST_SCMP;
				end else begin
					tbl_rd.start_addr = lo_q[ADDR_W-1:0];
					if (lo_q == '0) begin
						tbl_rd.ref_addr = '0;
					end else begin
						tbl_rd.ref_addr = ADDR_W'(lo_q - CNT_W'(1));
					end
					state_d = ST_FIN;
				end
			end
			ST_SCMP: begin
				if (!cmp_lt) begin
					lo_d = mid + CNT_W'(1);
				end else begin
					hi_d = mid;
				end
				state_d = ST_SEARCH;
			end
			ST_FIN: begin
				fin     = 1'b1;
				fin_pos = lo_q;
				fin_ref = ref_rd;
				if (lo_q < cnt) begin
					fin_next = {1'b0, start_rd};
				end else begin
					fin_next = NO_NEXT;
				end
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign fin_null  = fin_ref >= dict_size_q;
	assign fin_nulls = (fin_null && nulls_q != NULL_MAX) ? nulls_q + NULL_W'(1) : nulls_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_pos_q  <= '0;
			cur_next_q <= '0;
			cur_ref_q  <= '0;
			nulls_q    <= '0;
			valid_q    <= 1'b0;
		end else begin
			valid_q <= fin;
			if (fin) begin
				if (last_q) begin
					cur_pos_q  <= '0;
					cur_next_q <= '0;
					cur_ref_q  <= '0;
					nulls_q    <= '0;
				end else begin
					cur_pos_q  <= fin_pos;
					cur_next_q <= fin_next;
					cur_ref_q  <= fin_ref;
					nulls_q    <= fin_nulls;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_q <= lo_d;
		hi_q <= hi_d;
		if (accept) begin
			row_q  <= row_id;
			last_q <= last_in_batch;
		end
		if (fin) begin
			ref_res_q    <= fin_ref;
			is_null_q    <= fin_null;
			null_total_q <= fin_nulls;
			batch_done_q <= last_q;
		end
	end

	assign valid      = valid_q;
	assign ref_res    = ref_res_q;
	assign is_null    = is_null_q;
	assign null_total = null_total_q;
	assign batch_done = batch_done_q;

endmodule

[verif/run_table_row_ref_lookup_tb.sv]
// ----------------------------------------------------------------------------
// run_table_row_ref_lookup_tb - self-checking bench for the run table lookup
// Loads run tables over the item port and sets the run and dictionary counts
// over APB. A scoreboard predicts each lookup result from its own copy of the
// table and cursor and checks every valid strobe against it. The stimulus
// covers hand-picked corner cases, random batches under several idle patterns
// and a long batch in which every reference is null.
// ----------------------------------------------------------------------------
module run_table_row_ref_lookup_tb import rtrl_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE      = 40;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES      = 6;
	localparam int PHASE_ROWS  = 24;
	localparam int NULL_ROWS   = 20;
	localparam int IDLE_PCT [3] = '{0, 61, 13};

	typedef struct packed {
		logic [REF_W-1:0]  ref_val;
		logic              is_null;
		logic [NULL_W-1:0] null_total;
		logic              batch_done;
	} lookup_res_t;

	class run_table_sb;
		logic [ROW_W-1:0]  start_rows [MAX_RUNS];
		logic [REF_W-1:0]  run_refs [MAX_RUNS];
		int                cur_pos;
		int                cur_next;
		logic [REF_W-1:0]  cur_ref;
		logic [NULL_W-1:0] nulls_seen;
		logic [CNT_W-1:0]  run_count;
		logic [REF_W-1:0]  dict_size;
		lookup_res_t       lookups_due [$];
		int                errors;

		function new();
			cur_pos = 0;
			cur_next = 0;
			cur_ref = '0;
			nulls_seen = '0;
			run_count = CNT_W'(1);
			dict_size = '0;
			errors = 0;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10) begin
				$display("%s", msg);
			end
		endfunction

		function int active_runs();
			if (run_count == 0) begin
				return 1;
			end
			if (run_count > MAX_RUNS) begin
				return MAX_RUNS;
			end
			return int'(run_count);
		endfunction

		// first run whose start lies above the row, or cnt
		function int first_after(int row, int cnt);
			int lo;
			int hi;
			int mid;
			lo = 0;
			hi = cnt;
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if (int'(start_rows[mid]) <= row) begin
					lo = mid + 1;
				end else begin
					hi = mid;
				end
			end
			return lo;
		endfunction

		function void set_reg(logic sel, logic [APB_DW-1:0] val);
			if (sel == REG_RUN_COUNT) begin
				run_count = val[CNT_W-1:0];
			end else begin
				dict_size = val[REF_W-1:0];
			end
		endfunction

		function logic [APB_DW-1:0] reg_value(logic sel);
			if (sel == REG_RUN_COUNT) begin
				return APB_DW'(run_count);
			end
			return APB_DW'(dict_size);
		endfunction

		function void note_item(logic c, logic [ADDR_W-1:0] idx, logic [ROW_W-1:0] srow,
				logic [REF_W-1:0] rref, logic [ROW_W-1:0] row_in, logic lst);
			int cnt;
			int pos;
			int nxt;
			int row;
			logic [REF_W-1:0] cref;
			lookup_res_t res;
			if (c == CMD_LOAD) begin
				start_rows[idx] = srow;
				run_refs[idx] = rref;
				return;
			end
			cnt = active_runs();
			row = int'(row_in);
			pos = cur_pos;
			// a fresh cursor reads run 0 as it stands now
			if (pos == 0) begin
				nxt = int'(start_rows[0]);
				cref = run_refs[0];
			end else begin
				nxt = cur_next;
				cref = cur_ref;
			end
			if (pos >= cnt || row < nxt) begin
				// hold the cursor's run, even for a row behind it
			end else if (row == nxt) begin
				pos++;
				cref = run_refs[pos-1];
				nxt = (pos < cnt) ? int'(start_rows[pos]) : int'(NO_NEXT);
			end else begin
				pos = first_after(row, cnt);
				cref = run_refs[(pos == 0) ? 0 : pos - 1];
				nxt = (pos < cnt) ? int'(start_rows[pos]) : int'(NO_NEXT);
			end
			res.ref_val = cref;
			res.is_null = (cref >= dict_size);
			if (res.is_null && nulls_seen != NULL_MAX) begin
				nulls_seen++;
			end
			res.null_total = nulls_seen;
			res.batch_done = lst;
			lookups_due.push_back(res);
			if (lst) begin
				cur_pos = 0;
				cur_next = 0;
				cur_ref = '0;
				nulls_seen = '0;
			end else begin
				cur_pos = pos;
				cur_next = nxt;
				cur_ref = cref;
			end
		endfunction

		function void check_result(lookup_res_t got);
			lookup_res_t want;
			if (lookups_due.size() == 0) begin
				flag($sformatf("unexpected result: ref=%0d null=%0b count=%0d done=%0b",
					got.ref_val, got.is_null, got.null_total, got.batch_done));
				return;
			end
			want = lookups_due.pop_front();
			if (got.ref_val !== want.ref_val || got.is_null !== want.is_null ||
					got.null_total !== want.null_total || got.batch_done !== want.batch_done) begin
				flag($sformatf({"result mismatch: expected ref=%0d null=%0b count=%0d done=%0b,",
					" got ref=%0d null=%0b count=%0d done=%0b"},
					want.ref_val, want.is_null, want.null_total, want.batch_done,
					got.ref_val, got.is_null, got.null_total, got.batch_done));
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              cmd;
	logic [ADDR_W-1:0] run_index;
	logic [ROW_W-1:0]  run_start_row;
	logic [REF_W-1:0]  run_ref;
	logic [ROW_W-1:0]  row_id;
	logic              last_in_batch;
	logic              valid;
	logic [REF_W-1:0]  ref_res;
	logic              is_null;
	logic [NULL_W-1:0] null_total;
	logic              batch_done;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	run_table_sb sb;
	int          idle_pct;
	int          table_len;
	int          stall_cycles = 0;

	run_table_row_ref_lookup DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.run_index     (run_index),
		.run_start_row (run_start_row),
		.run_ref       (run_ref),
		.row_id        (row_id),
		.last_in_batch (last_in_batch),
		.valid         (valid),
		.ref_res       (ref_res),
		.is_null       (is_null),
		.null_total    (null_total),
		.batch_done    (batch_done),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// check results before noting the item taken at the same edge
	always @(posedge clk) begin : monitor
		lookup_res_t seen;
		if (arst_n) begin
			if (valid) begin
				seen.ref_val = ref_res;
				seen.is_null = is_null;
				seen.null_total = null_total;
				seen.batch_done = batch_done;
				sb.check_result(seen);
			end
			if (start && !busy) begin
				sb.note_item(cmd, run_index, run_start_row, run_ref, row_id, last_in_batch);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (valid || (start && !busy)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic send_item(logic c, logic [ADDR_W-1:0] idx, logic [ROW_W-1:0] srow,
			logic [REF_W-1:0] rref, logic [ROW_W-1:0] row, logic lst);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		cmd = c;
		run_index = idx;
		run_start_row = srow;
		run_ref = rref;
		row_id = row;
		last_in_batch = lst;
		start = 1'b1;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic load(int idx, int srow, int rref);
		send_item(CMD_LOAD, ADDR_W'(idx), ROW_W'(srow), REF_W'(rref), ROW_W'($urandom),
			1'($urandom));
	endtask

	task automatic lookup(int row, logic lst);
		send_item(CMD_LOOKUP, ADDR_W'($urandom), ROW_W'($urandom), REF_W'($urandom),
			ROW_W'(row), lst);
	endtask

	task automatic hold_until_drained();
		start = 1'b0;
		while (sb.lookups_due.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// wait until every lookup result is checked, then idle with start low
	task automatic quiesce();
		hold_until_drained();
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic sel, logic [APB_DW-1:0] val);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {sel, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		sb.set_reg(sel, val);
		@(negedge clk);
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		if (prdata !== sb.reg_value(sel)) begin
			sb.flag($sformatf("register %0d read back %0d, expected %0d",
				sel, prdata, sb.reg_value(sel)));
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic configure(int rc, int dc);
		quiesce();
		write_reg(REG_RUN_COUNT, APB_DW'(rc));
		write_reg(REG_DICT_SIZE, APB_DW'(dc));
	endtask

	// ascending starts with the odd out-of-order entry
	task automatic load_runs(int n, int step);
		int s;
		int i;
		int st;
		s = $urandom_range(1) ? 0 : int'($urandom_range(1, 400));
		for (i = 0; i < n; i++) begin
			st = ($urandom_range(99) < 3) ? int'($urandom_range(65535)) : s;
			load(i, st, int'($urandom_range(65535)));
			s = s + int'($urandom_range(step));
			if (s > 65535) begin
				s = 65535;
			end
		end
		if (n > table_len) begin
			table_len = n;
		end
	endtask

	task automatic run_batch(int n, int pause_at);
		int k;
		int cnt;
		int i;
		int row;
		int pick;
		int d;
		int idx;
		cnt = sb.active_runs();
		k = 0;
		for (i = 0; i < n; i++) begin
			if (i == pause_at) begin
				hold_until_drained();
			end
			pick = $urandom_range(99);
			if ($urandom_range(99) < 5) begin
				idx = $urandom_range(table_len - 1);
				load(idx, int'(sb.start_rows[idx]), int'($urandom_range(65535)));
			end
			if (pick < 40) begin
				if (k < cnt - 1 && $urandom_range(1)) begin
					k++;
				end
				row = int'(sb.start_rows[k]);
			end else if (pick < 65) begin
				d = $urandom_range(40);
				row = int'(sb.start_rows[k]) + d;
			end else if (pick < 75) begin
				k = $urandom_range(cnt - 1);
				d = $urandom_range(3);
				row = int'(sb.start_rows[k]) + d;
			end else if (pick < 85) begin
				row = $urandom_range(65535);
			end else if (pick < 93) begin
				d = $urandom_range(1, 5);
				row = int'(sb.start_rows[k]) - d;
			end else begin
				row = $urandom_range(1) ? 65535 : 0;
			end
			if (row > 65535) begin
				row = 65535;
			end
			if (row < 0) begin
				row = 0;
			end
			lookup(row, i == n - 1);
		end
	endtask

	task automatic directed();
		load(0, 100, 0);
		load(1, 200, 65535);
		load(2, 200, 7);
		load(3, 300, 16'h8000);
		load(4, 1000, 16'h7FFF);
		load(5, 2000, 1);
		load(6, 30000, 16'hFFFE);
		load(7, 65535, 16'h1234);
		table_len = 8;
		configure(8, 16'h8000);
		// row before the first run, step along, jump, step back, run to the end
		lookup(0, 1'b0);
		lookup(100, 1'b0);
		lookup(150, 1'b0);
		lookup(200, 1'b0);
		lookup(250, 1'b0);
		lookup(5000, 1'b0);
		lookup(150, 1'b0);
		lookup(65535, 1'b1);
		// cursor parked past the last run
		lookup(65535, 1'b0);
		lookup(40000, 1'b0);
		lookup(0, 1'b1);
		// load while the batch is open
		lookup(100, 1'b0);
		load(1, 200, 16'h0042);
		lookup(150, 1'b0);
		lookup(200, 1'b1);
		// shrink the run count under an open cursor
		lookup(5000, 1'b0);
		configure(3, 16'h8000);
		lookup(6000, 1'b1);
		// zero run count acts as one, every reference null
		configure(0, 0);
		lookup(50, 1'b0);
		lookup(100, 1'b1);
	endtask

	initial begin
		int ph;
		int n;
		int rows;
		int rc;
		int dc;
		int i;
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_LOAD;
		run_index = '0;
		run_start_row = '0;
		run_ref = '0;
		row_id = '0;
		last_in_batch = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_pct = 0;
		table_len = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed();

		for (ph = 0; ph < PHASES; ph++) begin
			idle_pct = IDLE_PCT[ph % 3];
			if (ph == 3) begin
				load_runs(MAX_RUNS, 63);
				rc = MAX_RUNS;
			end else if (ph == 4) begin
				rc = 2047;
			end else begin
				n = $urandom_range(1, 24);
				case ($urandom_range(2))
					0: load_runs(n, 4);
					1: load_runs(n, 300);
					default: load_runs(n, 6000);
				endcase
				case ($urandom_range(9))
					0: rc = 0;
					1: rc = 1;
					2: rc = n;
					3: rc = $urandom_range(1, table_len);
					default: rc = $urandom_range(1, n);
				endcase
			end
			case ($urandom_range(5))
				0: dc = 0;
				1: dc = 65535;
				default: dc = $urandom_range(65535);
			endcase
			configure(rc, dc);
			rows = 0;
			while (rows < PHASE_ROWS) begin
				n = $urandom_range(1, 16);
				run_batch(n, (rows == 0) ? int'($urandom_range(n - 1)) : -1);
				rows += n;
			end
		end

		// one long batch with every reference null, then a batch of one row
		idle_pct = 0;
		load(0, 0, int'($urandom_range(65535)));
		configure(1, 0);
		for (i = 0; i < NULL_ROWS; i++) begin
			lookup($urandom_range(65535), i == NULL_ROWS - 1);
		end
		lookup($urandom_range(65535), 1'b1);

		quiesce();
		if (sb.errors == 0 && sb.lookups_due.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

[filelist.f]
src/rtrl_pkg.sv
src/rtrl_table.sv
src/rtrl_cmp.sv
src/run_table_row_ref_lookup.sv
verif/run_table_row_ref_lookup_tb.sv
